FILE: rtl/priority_round_robin_task_scheduler_macros.svh
// assertion macros used by the scheduler datapath
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/prs_pkg.sv
// types and constants shared by the scheduler modules
package prs_pkg;

  localparam int MaxTasks = 32;
  localparam int SlotW    = 5;
  localparam int CountW   = 6;
  localparam int TickW    = 64;

  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_TERMINATE = 3'd1,
    OP_SLEEP     = 3'd2,
    OP_TICK      = 3'd3,
    OP_SCHEDULE  = 3'd4,
    OP_QUERY     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_READY      = 2'd0,
    ST_SLEEPING   = 2'd1,
    ST_TERMINATED = 2'd2
  } task_st_e;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_FULL    = 2'd1,
    RES_NO_SLOT = 2'd2
  } res_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WORK,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic start;
    logic work;
    logic emit;
  } prs_cmd_t;

  typedef struct packed {
    logic scan_op;
    logic last_step;
    logic out_full;
  } prs_sts_t;

endpackage

FILE: rtl/prs_ctrl.sv
// controller state machine of the scheduler
module prs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  prs_pkg::prs_sts_t sts_i,
  output prs_pkg::prs_cmd_t cmd_o
);
  import prs_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) state_d = FSM_WORK;
      end
      FSM_WORK: begin
        if (!sts_i.scan_op || sts_i.last_step) state_d = FSM_DONE;
      end
      FSM_DONE: begin
        if (!sts_i.out_full) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      FSM_WORK: cmd_o.work = 1'b1;
      FSM_DONE: cmd_o.emit = !sts_i.out_full;
      default: ;
    endcase
  end

endmodule

FILE: rtl/prs_datapath.sv
// task table, timers, scan logic and result register of the scheduler
`include "priority_round_robin_task_scheduler_macros.svh"

module prs_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  prs_pkg::prs_cmd_t            cmd_i,
  output prs_pkg::prs_sts_t            sts_o,
  input  logic [2:0]                   operation_i,
  input  logic [prs_pkg::SlotW-1:0]    task_slot_i,
  input  logic [7:0]                   new_priority_i,
  input  logic signed [31:0]           exit_value_i,
  input  logic [31:0]                  sleep_ticks_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [prs_pkg::SlotW-1:0]    result_slot_o,
  output logic [1:0]                   slot_state_o,
  output logic [7:0]                   slot_priority_o,
  output logic signed [31:0]           slot_exit_value_o,
  output logic [prs_pkg::CountW-1:0]   live_count_o
);
  import prs_pkg::*;

  // captured item
  logic [2:0]        op_q;
  logic [SlotW-1:0]  slot_q;
  logic [7:0]        nprio_q;
  logic [31:0]       exit_q;
  logic [31:0]       dur_q;

  // task table
  task_st_e          stat_q  [MaxTasks];
  logic [7:0]        tprio_q [MaxTasks];
  logic              ev_q    [MaxTasks];
  logic [TickW-1:0]  wake_mem [MaxTasks];
  logic [31:0]       exit_mem [MaxTasks];
  logic [TickW-1:0]  wake_rd_q;
  logic [31:0]       exit_rd_q;

  logic [CountW-1:0] alloc_q;
  logic [CountW-1:0] live_q;
  logic [SlotW-1:0]  run_q;
  logic [TickW-1:0]  tick_q;

  // scan state
  logic [SlotW-1:0]  pos_q, pos_d;
  logic [CountW-1:0] steps_q;
  logic              found_q;
  logic [SlotW-1:0]  best_q;
  logic [7:0]        bprio_q;

  // result held until the output register is free
  logic [1:0]        res_status_q, res_status_d;
  logic [SlotW-1:0]  res_slot_q, res_slot_d;
  logic [1:0]        res_state_q, res_state_d;
  logic [7:0]        res_prio_q, res_prio_d;
  logic [31:0]       res_exit_q, res_exit_d;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [SlotW-1:0]  out_slot_q;
  logic [1:0]        out_state_q;
  logic [7:0]        out_prio_q;
  logic [31:0]       out_exit_q;
  logic [CountW-1:0] out_live_q;

  logic [SlotW-1:0]  alloc_idx;
  logic [SlotW-1:0]  alloc_m1;
  logic [SlotW-1:0]  pos_next;
  logic [SlotW-1:0]  start_pos;
  logic              full;
  logic              in_range;
  logic              scan_op;
  logic              last_step;
  logic              take;
  logic              due;
  logic [SlotW-1:0]  pick;
  task_st_e          cur_st;
  logic [7:0]        cur_prio;

  assign alloc_idx = alloc_q[SlotW-1:0];
  assign alloc_m1  = SlotW'(alloc_q - CountW'(1));
  assign full      = (alloc_q == CountW'(MaxTasks));
  assign in_range  = ({1'b0, slot_q} < alloc_q);
  assign scan_op   = (op_q == OP_TICK) || (op_q == OP_SCHEDULE);
  assign last_step = (steps_q == CountW'(1));
  assign cur_st    = stat_q[pos_q];
  assign cur_prio  = tprio_q[pos_q];
  assign pos_next  = (pos_q == '0) ? alloc_m1 : pos_q - SlotW'(1);
  assign take      = (cur_st == ST_READY) && (!found_q || (cur_prio > bprio_q));
  assign due       = (tick_q >= wake_rd_q);
  assign pick      = take ? pos_q : (found_q ? best_q : '0);

  assign sts_o.scan_op   = scan_op;
  assign sts_o.last_step = last_step;
  assign sts_o.out_full  = out_valid_q && !out_ready_i;

  // terminate, sleep and query work at the scan position; create uses the allocation index
  always_comb begin
    case (operation_i)
      OP_TERMINATE, OP_QUERY: start_pos = task_slot_i;
      OP_SLEEP:               start_pos = run_q;
      OP_SCHEDULE:            start_pos = (run_q == '0) ? alloc_m1 : run_q - SlotW'(1);
      OP_TICK:                start_pos = alloc_m1;
      default:                start_pos = '0;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.start) begin
      pos_d = start_pos;
    end else if (cmd_i.work && scan_op) begin
      pos_d = pos_next;
    end
  end

  always_comb begin
    res_status_d = RES_OK;
    res_slot_d   = '0;
    res_state_d  = '0;
    res_prio_d   = '0;
    res_exit_d   = '0;
    case (op_q)
      OP_CREATE: begin
        if (full) res_status_d = RES_FULL;
        else      res_slot_d   = alloc_idx;
      end
      OP_TERMINATE: begin
        res_slot_d = slot_q;
        if (!in_range) res_status_d = RES_NO_SLOT;
      end
      OP_SLEEP:    res_slot_d = run_q;
      OP_SCHEDULE: res_slot_d = pick;
      OP_QUERY: begin
        res_slot_d = slot_q;
        if (!in_range) begin
          res_status_d = RES_NO_SLOT;
        end else begin
          res_state_d = cur_st;
          res_prio_d  = cur_prio;
          res_exit_d  = ev_q[pos_q] ? exit_rd_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxTasks; i++) begin
        stat_q[i]  <= ST_READY;
        tprio_q[i] <= '0;
        ev_q[i]    <= 1'b0;
      end
      alloc_q     <= CountW'(1);
      live_q      <= CountW'(1);
      run_q       <= '0;
      tick_q      <= '0;
      pos_q       <= '0;
      steps_q     <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      bprio_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (cmd_i.start) begin
        steps_q <= alloc_q;
        found_q <= 1'b0;
        if (operation_i == OP_TICK) tick_q <= tick_q + TickW'(1);
      end
      if (cmd_i.work) begin
        case (op_q)
          OP_CREATE: begin
            if (!full) begin
              stat_q[alloc_idx]  <= ST_READY;
              tprio_q[alloc_idx] <= nprio_q;
              ev_q[alloc_idx]    <= 1'b0;
              alloc_q            <= alloc_q + CountW'(1);
              live_q             <= live_q + CountW'(1);
            end
          end
          OP_TERMINATE: begin
            if (in_range) begin
              if (cur_st != ST_TERMINATED) live_q <= live_q - CountW'(1);
              stat_q[pos_q] <= ST_TERMINATED;
              ev_q[pos_q]   <= 1'b1;
            end
          end
          OP_SLEEP: begin
            // a terminated task put to sleep counts as live again
            if (cur_st == ST_TERMINATED) live_q <= live_q + CountW'(1);
            stat_q[pos_q] <= ST_SLEEPING;
          end
          OP_TICK: begin
            if (cur_st == ST_SLEEPING && due) stat_q[pos_q] <= ST_READY;
            steps_q <= steps_q - CountW'(1);
          end
          OP_SCHEDULE: begin
            if (take) begin
              found_q <= 1'b1;
              best_q  <= pos_q;
              bprio_q <= cur_prio;
            end
            steps_q <= steps_q - CountW'(1);
            if (last_step) run_q <= pick;
          end
          default: ;
        endcase
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // timer and exit code stores, read at the next scan position
  always_ff @(posedge clk_i) begin
    if (cmd_i.work && op_q == OP_SLEEP) begin
      wake_mem[pos_q] <= tick_q + {32'b0, dur_q};
    end
    wake_rd_q <= wake_mem[pos_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.work && op_q == OP_TERMINATE && in_range) begin
      exit_mem[pos_q] <= exit_q;
    end
    exit_rd_q <= exit_mem[pos_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q    <= operation_i;
      slot_q  <= task_slot_i;
      nprio_q <= new_priority_i;
      exit_q  <= exit_value_i;
      dur_q   <= sleep_ticks_i;
    end
    if (cmd_i.work) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_state_q  <= res_state_d;
      res_prio_q   <= res_prio_d;
      res_exit_q   <= res_exit_d;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_state_q  <= res_state_q;
      out_prio_q   <= res_prio_q;
      out_exit_q   <= res_exit_q;
      out_live_q   <= live_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign result_slot_o     = out_slot_q;
  assign slot_state_o      = out_state_q;
  assign slot_priority_o   = out_prio_q;
  assign slot_exit_value_o = out_exit_q;
  assign live_count_o      = out_live_q;

  `PRS_ASSERT_IMP(a_live_le_alloc, clk_i, rst_ni, 1'b1, live_q <= alloc_q, "live count above allocation")
  `PRS_ASSERT_IMP(a_alloc_range, clk_i, rst_ni, 1'b1, (alloc_q != '0) && (alloc_q <= CountW'(MaxTasks)), "allocation count out of range")
  `PRS_ASSERT_IMP(a_run_alloc, clk_i, rst_ni, 1'b1, {1'b0, run_q} < alloc_q, "running slot not allocated")
  `PRS_ASSERT_NXT(a_emit_valid, clk_i, rst_ni, cmd_i.emit, out_valid_q, "result lost on emit")

endmodule

FILE: rtl/priority_round_robin_task_scheduler.sv
// one item at a time: accept, then work (tick and schedule visit each allocated slot
// in turn, scanned through the task table), then load the output register once it
// is free. the next transfer is taken while a result waits.
// reset: slot 0 ready as the only allocated task, running slot 0, tick counter 0,
// no clearing pass.
module priority_round_robin_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation, task_slot, new_priority, exit_value, sleep_ticks
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, result_slot, slot_state, slot_priority, slot_exit_value, live_count, pad
  output logic [55:0] m_axis_tdata
);
  import prs_pkg::*;

  prs_cmd_t           cmd;
  prs_sts_t           sts;
  logic [1:0]         status;
  logic [SlotW-1:0]   result_slot;
  logic [1:0]         slot_state;
  logic [7:0]         slot_priority;
  logic signed [31:0] slot_exit_value;
  logic [CountW-1:0]  live_count;

  prs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prs_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .operation_i       (s_axis_tdata[2:0]),
    .task_slot_i       (s_axis_tdata[7:3]),
    .new_priority_i    (s_axis_tdata[15:8]),
    .exit_value_i      (s_axis_tdata[47:16]),
    .sleep_ticks_i     (s_axis_tdata[79:48]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .status_o          (status),
    .result_slot_o     (result_slot),
    .slot_state_o      (slot_state),
    .slot_priority_o   (slot_priority),
    .slot_exit_value_o (slot_exit_value),
    .live_count_o      (live_count)
  );

  assign m_axis_tdata = {1'b0, live_count, slot_exit_value, slot_priority,
                         slot_state, result_slot, status};

endmodule
